FILE: rtl/motion_command_handshake_fsm_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the motion command handshake sequencer
// Concurrent checks in simulation, empty bodies for synthesis.
// ---------------------------------------------------------------------------
`ifndef MOTION_COMMAND_HANDSHAKE_FSM_DEFINES_SVH
`define MOTION_COMMAND_HANDSHAKE_FSM_DEFINES_SVH

`ifndef SYNTHESIS
// check that is switched off while reset is applied
`define MCHS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("mchs assertion failed");
// check that holds during reset as well
`define MCHS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("mchs assertion failed");
`else
`define MCHS_ASSERT(lbl, clk, rstn, prop)
`define MCHS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/mchs_pkg.sv
// ---------------------------------------------------------------------------
// mchs_pkg
// Shared types and constants of the motion command handshake sequencer.
// ---------------------------------------------------------------------------
package mchs_pkg;

  // sequence phases
  typedef enum logic [2:0] {
    PH_ENTRY   = 3'd0,
    PH_SEND_RA = 3'd1,
    PH_WAIT_RA = 3'd2,
    PH_START   = 3'd3,
    PH_VERIFY  = 3'd4,
    PH_MONITOR = 3'd5,
    PH_TM_ACK  = 3'd6
  } phase_e;

  // reply codes on ra_response / tm_response
  localparam logic [1:0] RESP_ACK = 2'd1;
  localparam logic [1:0] RESP_NAK = 2'd2;

  // finish codes
  localparam logic [2:0] FIN_NONE      = 3'd0;
  localparam logic [2:0] FIN_TM_ACKED  = 3'd1;
  localparam logic [2:0] FIN_TM_RESENT = 3'd2;
  localparam logic [2:0] FIN_RA_NAK    = 3'd3;
  localparam logic [2:0] FIN_NO_RA_ACK = 3'd4;
  localparam logic [2:0] FIN_STOPPED   = 3'd5;

  // timer slots
  localparam int unsigned TMR_RA     = 0;
  localparam int unsigned TMR_MOTION = 1;
  localparam int unsigned TMR_TM     = 2;
  localparam int unsigned NUM_TMR    = 3;

  // configuration registers
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;
  localparam logic REG_LINK_TIMEOUT   = 1'b0;
  localparam logic REG_MOTION_TIMEOUT = 1'b1;
  localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd1000;

  // one input word
  typedef struct packed {
    logic       restart;
    logic [1:0] ra_response;
    logic [1:0] tm_response;
    logic       motion_ongoing;
    logic       start_accepted;
    logic       stop_request;
  } item_t;

  // one result word
  typedef struct packed {
    logic       done_res;
    logic [2:0] finish_code;
    logic       send_ra;
    logic       start_motion;
    logic       send_tm;
    logic       tm_resend;
    logic       mode_fault;
  } result_t;

  // timer control from the sequencer
  typedef struct packed {
    logic [NUM_TMR-1:0] arm;
    logic [NUM_TMR-1:0] clr;
  } tmr_ctrl_t;

endpackage

FILE: rtl/motion_command_handshake_fsm.sv
// The input word is accepted into the input register, and its result is then loaded
// into the result register once that register is free or being read.
// One word per cycle unless a result waits; phase, timers and flags update in one pass.
// A new word is taken while a result waits, as long as the input register frees up.
// Reset (rst_ni, asynchronous, active low): entry phase, timers disarmed, flags clear,
// both timeouts 1000 ticks, input and result registers empty.
// ---------------------------------------------------------------------------
// motion_command_handshake_fsm
// Motion command handshake sequencer: permission request, motion start,
// monitoring and report, one tick per input word.
// ---------------------------------------------------------------------------
`include "motion_command_handshake_fsm_defines.svh"

module motion_command_handshake_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mchs_pkg::PADDR_W-1:0]  paddr,
  input  logic [mchs_pkg::PDATA_W-1:0]  pwdata,
  output logic [mchs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  input  logic [1:0]                    ra_response_i,
  input  logic [1:0]                    tm_response_i,
  input  logic                          motion_ongoing_i,
  input  logic                          start_accepted_i,
  input  logic                          stop_request_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          done_res_o,
  output logic [2:0]                    finish_code_o,
  output logic                          send_ra_o,
  output logic                          start_motion_o,
  output logic                          send_tm_o,
  output logic                          tm_resend_o,
  output logic                          mode_fault_o
);

  logic                                in_valid_q;
  mchs_pkg::item_t                     item_q;
  logic                                out_valid_q;
  mchs_pkg::result_t                   res_q;
  mchs_pkg::result_t                   res;
  mchs_pkg::tmr_ctrl_t                 tmr_ctrl;
  logic [mchs_pkg::NUM_TMR-1:0]        expired;
  logic [mchs_pkg::TICK_W-1:0]         link_ticks;
  logic [mchs_pkg::TICK_W-1:0]         motion_ticks;
  logic                                step_fire;
  logic                                in_fire;

  // handshake
  assign step_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.restart        <= restart_i;
      item_q.ra_response    <= ra_response_i;
      item_q.tm_response    <= tm_response_i;
      item_q.motion_ongoing <= motion_ongoing_i;
      item_q.start_accepted <= start_accepted_i;
      item_q.stop_request   <= stop_request_i;
    end
  end

  mchs_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .link_ticks_o   (link_ticks),
    .motion_ticks_o (motion_ticks)
  );

  mchs_timers u_tmr (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (step_fire),
    .ctrl_i         (tmr_ctrl),
    .link_ticks_i   (link_ticks),
    .motion_ticks_i (motion_ticks),
    .expired_o      (expired)
  );

  mchs_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (step_fire),
    .item_i    (item_q),
    .expired_i (expired),
    .res_o     (res),
    .tmr_o     (tmr_ctrl)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign done_res_o     = res_q.done_res;
  assign finish_code_o  = res_q.finish_code;
  assign send_ra_o      = res_q.send_ra;
  assign start_motion_o = res_q.start_motion;
  assign send_tm_o      = res_q.send_tm;
  assign tm_resend_o    = res_q.tm_resend;
  assign mode_fault_o   = res_q.mode_fault;

  // checks
  `MCHS_ASSERT(a_code_iff_done, clk_i, rst_ni,
    out_valid_q |-> (res_q.done_res == (res_q.finish_code != mchs_pkg::FIN_NONE)))
  `MCHS_ASSERT(a_step_loads_result, clk_i, rst_ni, step_fire |=> out_valid_q)
  `MCHS_ASSERT(a_held_word_waits, clk_i, rst_ni,
    (in_valid_q && !step_fire) |=> (in_valid_q && $stable(item_q)))
  `MCHS_ASSERT(a_one_issue, clk_i, rst_ni,
    out_valid_q |-> ($countones({res_q.send_ra, res_q.start_motion,
                                 res_q.send_tm, res_q.tm_resend}) <= 1))
  `MCHS_ASSERT_ALWAYS(a_pready_high, clk_i, pready)

endmodule

FILE: rtl/mchs_cfg_regs.sv
// ---------------------------------------------------------------------------
// mchs_cfg_regs
// APB-style register file holding the two timeout settings.
// ---------------------------------------------------------------------------
module mchs_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mchs_pkg::PADDR_W-1:0]        paddr,
  input  logic [mchs_pkg::PDATA_W-1:0]        pwdata,
  output logic [mchs_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  output logic [mchs_pkg::TICK_W-1:0]         link_ticks_o,
  output logic [mchs_pkg::TICK_W-1:0]         motion_ticks_o
);

  logic [mchs_pkg::TICK_W-1:0] link_q;
  logic [mchs_pkg::TICK_W-1:0] motion_q;
  logic                        wr_en;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q   <= mchs_pkg::TIMEOUT_RST;
      motion_q <= mchs_pkg::TIMEOUT_RST;
    end else if (wr_en) begin
      if (reg_sel == mchs_pkg::REG_LINK_TIMEOUT) begin
        link_q <= pwdata[mchs_pkg::TICK_W-1:0];
      end else begin
        motion_q <= pwdata[mchs_pkg::TICK_W-1:0];
      end
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (reg_sel == mchs_pkg::REG_LINK_TIMEOUT) begin
      prdata[mchs_pkg::TICK_W-1:0] = link_q;
    end else begin
      prdata[mchs_pkg::TICK_W-1:0] = motion_q;
    end
  end

  assign link_ticks_o   = link_q;
  assign motion_ticks_o = motion_q;

endmodule

FILE: rtl/mchs_timers.sv
// ---------------------------------------------------------------------------
// mchs_timers
// Three countdown timers (RA, motion command, TM) with latched expiry flags.
// ---------------------------------------------------------------------------
module mchs_timers (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              tick_i,
  input  mchs_pkg::tmr_ctrl_t               ctrl_i,
  input  logic [mchs_pkg::TICK_W-1:0]       link_ticks_i,
  input  logic [mchs_pkg::TICK_W-1:0]       motion_ticks_i,
  output logic [mchs_pkg::NUM_TMR-1:0]      expired_o
);

  for (genvar t = 0; t < mchs_pkg::NUM_TMR; t++) begin : g_tmr
    logic [mchs_pkg::TICK_W-1:0] cnt_q, cnt_d;
    logic                        armed_q, armed_d;
    logic                        exp_q, exp_d;
    logic [mchs_pkg::TICK_W-1:0] ticks;
    logic                        hit;

    assign ticks = (t == mchs_pkg::TMR_MOTION) ? motion_ticks_i : link_ticks_i;
    // counter reaches zero on this tick
    assign hit          = armed_q && (cnt_q == mchs_pkg::TICK_W'(1));
    assign expired_o[t] = exp_q || hit;

    // next timer state: arm overrides the tick update
    always_comb begin
      cnt_d   = cnt_q;
      armed_d = armed_q;
      exp_d   = exp_q;
      if (ctrl_i.arm[t]) begin
        cnt_d   = (ticks == '0) ? mchs_pkg::TICK_W'(1) : ticks;
        armed_d = 1'b1;
        exp_d   = 1'b0;
      end else begin
        if (armed_q) begin
          cnt_d = cnt_q - mchs_pkg::TICK_W'(1);
        end
        armed_d = armed_q && !hit;
        exp_d   = expired_o[t] && !ctrl_i.clr[t];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q   <= '0;
        armed_q <= 1'b0;
        exp_q   <= 1'b0;
      end else if (tick_i) begin
        cnt_q   <= cnt_d;
        armed_q <= armed_d;
        exp_q   <= exp_d;
      end
    end
  end

endmodule

FILE: rtl/mchs_seq.sv
// ---------------------------------------------------------------------------
// mchs_seq
// Phase state machine: one tick per input word, result and timer controls.
// ---------------------------------------------------------------------------
module mchs_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           tick_i,
  input  mchs_pkg::item_t                item_i,
  input  logic [mchs_pkg::NUM_TMR-1:0]   expired_i,
  output mchs_pkg::result_t              res_o,
  output mchs_pkg::tmr_ctrl_t            tmr_o
);

  mchs_pkg::phase_e phase_q, phase_d, ph;
  logic             resend_q, resend_d;
  logic             stop_q, stop_d;
  logic             stop_v;
  logic             resp_ra_ack, resp_ra_nak, resp_tm_ack, resp_tm_nak;

  // restart forces entry before the phase logic; stop pulse latched first
  assign ph     = item_i.restart ? mchs_pkg::PH_ENTRY : phase_q;
  assign stop_v = stop_q || item_i.stop_request;

  assign resp_ra_ack = (item_i.ra_response == mchs_pkg::RESP_ACK);
  assign resp_ra_nak = (item_i.ra_response == mchs_pkg::RESP_NAK);
  assign resp_tm_ack = (item_i.tm_response == mchs_pkg::RESP_ACK);
  assign resp_tm_nak = (item_i.tm_response == mchs_pkg::RESP_NAK);

  // next state
  always_comb begin
    phase_d  = ph;
    resend_d = resend_q;
    stop_d   = stop_v;
    case (ph)
      mchs_pkg::PH_ENTRY: begin
        phase_d = mchs_pkg::PH_SEND_RA;
      end
      mchs_pkg::PH_SEND_RA: begin
        phase_d = mchs_pkg::PH_WAIT_RA;
      end
      mchs_pkg::PH_WAIT_RA: begin
        if (resp_ra_ack) begin
          phase_d  = mchs_pkg::PH_START;
          resend_d = 1'b0;
        end else if (resp_ra_nak) begin
          resend_d = 1'b0;
        end else if (expired_i[mchs_pkg::TMR_RA]) begin
          resend_d = !resend_q;
          if (!resend_q) begin
            phase_d = mchs_pkg::PH_SEND_RA;
          end
        end
      end
      mchs_pkg::PH_START: begin
        if (item_i.start_accepted) begin
          phase_d = mchs_pkg::PH_VERIFY;
        end
      end
      mchs_pkg::PH_VERIFY: begin
        if (item_i.motion_ongoing) begin
          phase_d = mchs_pkg::PH_MONITOR;
        end
        // motion timeout: resend once, the first timeout overriding the move to monitor
        if (expired_i[mchs_pkg::TMR_MOTION]) begin
          resend_d = !resend_q;
          if (!resend_q) begin
            phase_d = mchs_pkg::PH_START;
          end
        end
      end
      mchs_pkg::PH_MONITOR: begin
        if (stop_v) begin
          stop_d = 1'b0;
        end else if (!item_i.motion_ongoing) begin
          phase_d = mchs_pkg::PH_TM_ACK;
        end
      end
      mchs_pkg::PH_TM_ACK: begin
        phase_d = mchs_pkg::PH_TM_ACK;
      end
      default: begin
        phase_d = mchs_pkg::PH_ENTRY;
      end
    endcase
  end

  // result word and timer controls
  always_comb begin
    res_o = '0;
    tmr_o = '0;
    case (ph)
      mchs_pkg::PH_ENTRY: begin
        res_o = '0;
      end
      mchs_pkg::PH_SEND_RA: begin
        res_o.send_ra             = 1'b1;
        tmr_o.arm[mchs_pkg::TMR_RA] = 1'b1;
      end
      mchs_pkg::PH_WAIT_RA: begin
        if (resp_ra_nak && !resp_ra_ack) begin
          res_o.done_res    = 1'b1;
          res_o.finish_code = mchs_pkg::FIN_RA_NAK;
        end else if (!resp_ra_ack) begin
          tmr_o.clr[mchs_pkg::TMR_RA] = 1'b1;
          if (expired_i[mchs_pkg::TMR_RA] && resend_q) begin
            res_o.done_res    = 1'b1;
            res_o.finish_code = mchs_pkg::FIN_NO_RA_ACK;
          end
        end
      end
      mchs_pkg::PH_START: begin
        res_o.start_motion = 1'b1;
        res_o.mode_fault   = item_i.motion_ongoing || !item_i.start_accepted;
        tmr_o.arm[mchs_pkg::TMR_MOTION] = item_i.start_accepted;
      end
      mchs_pkg::PH_VERIFY: begin
        tmr_o.clr[mchs_pkg::TMR_MOTION] = 1'b1;
        res_o.mode_fault = expired_i[mchs_pkg::TMR_MOTION] && resend_q;
      end
      mchs_pkg::PH_MONITOR: begin
        if (stop_v) begin
          res_o.done_res    = 1'b1;
          res_o.finish_code = mchs_pkg::FIN_STOPPED;
        end else if (!item_i.motion_ongoing) begin
          res_o.send_tm               = 1'b1;
          tmr_o.arm[mchs_pkg::TMR_TM] = 1'b1;
        end
      end
      mchs_pkg::PH_TM_ACK: begin
        if (resp_tm_ack) begin
          res_o.done_res    = 1'b1;
          res_o.finish_code = mchs_pkg::FIN_TM_ACKED;
        end else begin
          // timer flag is only cleared when no NAK came in
          tmr_o.clr[mchs_pkg::TMR_TM] = !resp_tm_nak;
          if (resp_tm_nak || expired_i[mchs_pkg::TMR_TM]) begin
            res_o.tm_resend   = 1'b1;
            res_o.done_res    = 1'b1;
            res_o.finish_code = mchs_pkg::FIN_TM_RESENT;
          end
        end
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  // state registers, advanced once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mchs_pkg::PH_ENTRY;
      resend_q <= 1'b0;
      stop_q   <= 1'b0;
    end else if (tick_i) begin
      phase_q  <= phase_d;
      resend_q <= resend_d;
      stop_q   <= stop_d;
    end
  end

endmodule
